### rtl/core/plbu_pkg.sv
// Package: shared types, constants and controller encodings for the price-level book.
`default_nettype none
package plbu_pkg;
	localparam int LEVELS_DEF  = 4096;
	localparam int SYMBOLS_DEF = 4;
	localparam int SYM_W   = 2;
	localparam int PRICE_W = 24;
	localparam int VOL_W   = 32;
	localparam int LVL_W   = 12;
	localparam int LB_W    = 16;
	localparam int TICK_W  = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_SIZE   = 1'd1;
	localparam logic [LB_W-1:0]   LOWER_BOUND_RST = 16'd0;
	localparam logic [TICK_W-1:0] TICK_SIZE_RST   = 11'd100;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SCALE, ST_CHECK, ST_READ, ST_UPDATE,
		ST_ASK_SCAN, ST_BID_SCAN, ST_RD_TOP, ST_RESULT, ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load_in;
		logic scale;
		logic check;
		logic rd_levels;
		logic update;
		logic ask_scan_start;
		logic ask_scan_step;
		logic bid_scan_start;
		logic bid_scan_step;
		logic rd_top;
		logic make_result;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic sym_ok;
		logic in_range;
		logic ask_scan_need;
		logic bid_scan_need;
		logic ask_scan_done;
		logic bid_scan_done;
	} status_t;
endpackage
`default_nettype wire

### rtl/core/plbu_if.sv
// Interfaces: update, result and configuration channels.
`default_nettype none
interface plbu_upd_if;
	logic valid;
	logic ready;
	logic [plbu_pkg::SYM_W-1:0]   symbol;
	logic [plbu_pkg::PRICE_W-1:0] ask_px;
	logic [plbu_pkg::VOL_W-1:0]   ask_qty;
	logic [plbu_pkg::PRICE_W-1:0] bid_px;
	logic [plbu_pkg::VOL_W-1:0]   bid_qty;
	modport source (output valid, symbol, ask_px, ask_qty, bid_px, bid_qty,
		input ready);
	modport sink (input valid, symbol, ask_px, ask_qty, bid_px, bid_qty,
		output ready);
endinterface

interface plbu_res_if;
	logic valid;
	logic ready;
	logic                         accepted;
	logic                         ask_best_valid;
	logic [plbu_pkg::LVL_W-1:0]   ask_best_level;
	logic [plbu_pkg::VOL_W-1:0]   ask_best_volume;
	logic                         bid_best_valid;
	logic [plbu_pkg::LVL_W-1:0]   bid_best_level;
	logic [plbu_pkg::VOL_W-1:0]   bid_best_volume;
	modport source (output valid, accepted, ask_best_valid, ask_best_level, ask_best_volume,
		bid_best_valid, bid_best_level, bid_best_volume, input ready);
	modport sink (input valid, accepted, ask_best_valid, ask_best_level, ask_best_volume,
		bid_best_valid, bid_best_level, bid_best_volume, output ready);
endinterface

interface plbu_cfg_if;
	logic valid;
	logic ready;
	logic [plbu_pkg::CFG_IDX_W-1:0]  index;
	logic [plbu_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/price_level_book_update_core.sv
// Top level: price-level book update core with config registers, controller and datapath.
//
// Channel | Dir | Handshake   | Payload
// upd     | in  | valid/ready | symbol, ask/bid price and volume
// res     | out | valid/ready | accepted, best ask/bid valid, level, volume
// cfg     | in  | valid/ready | index, data (0 lower_bound, 1 tick_size)
//
// An accepted update that needs no rescan passes through capture, scale, check, read,
// write, top read, result and transfer.
// Clearing a tracked extreme adds a rescan that reads one level at a time, up to LEVELS-1
// levels per side; the single read port of each volume memory sets this.
// After reset a clearing pass over all SYMBOLS*2^clog2(LEVELS) addresses runs with upd.ready low.
// A stalled result holds the block; the next update is taken after its transfer.
`default_nettype none
module price_level_book_update_core #(
	parameter int LEVELS  = plbu_pkg::LEVELS_DEF,
	parameter int SYMBOLS = plbu_pkg::SYMBOLS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	plbu_upd_if.sink   upd,
	plbu_res_if.source res,
	plbu_cfg_if.sink   cfg
);
	plbu_pkg::cmd_t    cmd;
	plbu_pkg::status_t sts;
	logic [plbu_pkg::LB_W-1:0]   lower_bound_q;
	logic [plbu_pkg::TICK_W-1:0] tick_size_q;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_bound_q <= plbu_pkg::LOWER_BOUND_RST;
			tick_size_q   <= plbu_pkg::TICK_SIZE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				plbu_pkg::REG_LOWER_BOUND: lower_bound_q <= cfg.data;
				plbu_pkg::REG_TICK_SIZE:   tick_size_q <= cfg.data[plbu_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	plbu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (upd.valid),
		.in_ready  (upd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	plbu_dp #(.LEVELS(LEVELS), .SYMBOLS(SYMBOLS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.lower_bound     (lower_bound_q),
		.tick_size       (tick_size_q),
		.symbol          (upd.symbol),
		.ask_px          (upd.ask_px),
		.ask_qty         (upd.ask_qty),
		.bid_px          (upd.bid_px),
		.bid_qty         (upd.bid_qty),
		.accepted        (res.accepted),
		.ask_best_valid  (res.ask_best_valid),
		.ask_best_level  (res.ask_best_level),
		.ask_best_volume (res.ask_best_volume),
		.bid_best_valid  (res.bid_best_valid),
		.bid_best_level  (res.bid_best_level),
		.bid_best_volume (res.bid_best_volume)
	);
endmodule
`default_nettype wire

### rtl/core/plbu_ctrl.sv
// Controller: sequences clear, level check, read-modify-write, scans and result.
`default_nettype none
module plbu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output plbu_pkg::cmd_t         cmd,
	input  wire plbu_pkg::status_t sts
);
	plbu_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plbu_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			plbu_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) state_d = plbu_pkg::ST_IDLE;
			end
			plbu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = plbu_pkg::ST_SCALE;
				end
			end
			plbu_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = plbu_pkg::ST_CHECK;
			end
			plbu_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				if (!sts.sym_ok) state_d = plbu_pkg::ST_RESULT;
				else if (!sts.in_range) state_d = plbu_pkg::ST_RD_TOP;
				else state_d = plbu_pkg::ST_READ;
			end
			plbu_pkg::ST_READ: begin
				cmd.rd_levels = 1'b1;
				state_d = plbu_pkg::ST_UPDATE;
			end
			plbu_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				if (sts.ask_scan_need) begin
					cmd.ask_scan_start = 1'b1;
					state_d = plbu_pkg::ST_ASK_SCAN;
				end else if (sts.bid_scan_need) begin
					cmd.bid_scan_start = 1'b1;
					state_d = plbu_pkg::ST_BID_SCAN;
				end else begin
					state_d = plbu_pkg::ST_RD_TOP;
				end
			end
			plbu_pkg::ST_ASK_SCAN: begin
				cmd.ask_scan_step = 1'b1;
				if (sts.ask_scan_done) begin
					if (sts.bid_scan_need) begin
						cmd.bid_scan_start = 1'b1;
						state_d = plbu_pkg::ST_BID_SCAN;
					end else begin
						state_d = plbu_pkg::ST_RD_TOP;
					end
				end
			end
			plbu_pkg::ST_BID_SCAN: begin
				cmd.bid_scan_step = 1'b1;
				if (sts.bid_scan_done) state_d = plbu_pkg::ST_RD_TOP;
			end
			plbu_pkg::ST_RD_TOP: begin
				cmd.rd_top = 1'b1;
				state_d = plbu_pkg::ST_RESULT;
			end
			plbu_pkg::ST_RESULT: begin
				cmd.make_result = 1'b1;
				state_d = plbu_pkg::ST_OUT;
			end
			plbu_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = plbu_pkg::ST_IDLE;
			end
			default: state_d = plbu_pkg::ST_CLEAR;
		endcase
	end

	// No update is taken before the clearing pass has finished
	ast_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plbu_pkg::ST_CLEAR |-> !in_ready)
		else $error("update taken during clear");
	// Result held until taken
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	// Never take input while a result is pending
	ast_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output overlap");
endmodule
`default_nettype wire

### rtl/core/plbu_dp.sv
// Datapath: level scaling, volume memories, tracked extremes and result register.
`default_nettype none
module plbu_dp #(
	parameter int LEVELS  = plbu_pkg::LEVELS_DEF,
	parameter int SYMBOLS = plbu_pkg::SYMBOLS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire plbu_pkg::cmd_t                cmd,
	output plbu_pkg::status_t                  sts,
	input  wire logic [plbu_pkg::LB_W-1:0]     lower_bound,
	input  wire logic [plbu_pkg::TICK_W-1:0]   tick_size,
	input  wire logic [plbu_pkg::SYM_W-1:0]    symbol,
	input  wire logic [plbu_pkg::PRICE_W-1:0]  ask_px,
	input  wire logic [plbu_pkg::VOL_W-1:0]    ask_qty,
	input  wire logic [plbu_pkg::PRICE_W-1:0]  bid_px,
	input  wire logic [plbu_pkg::VOL_W-1:0]    bid_qty,
	output logic                               accepted,
	output logic                               ask_best_valid,
	output logic [plbu_pkg::LVL_W-1:0]         ask_best_level,
	output logic [plbu_pkg::VOL_W-1:0]         ask_best_volume,
	output logic                               bid_best_valid,
	output logic [plbu_pkg::LVL_W-1:0]         bid_best_level,
	output logic [plbu_pkg::VOL_W-1:0]         bid_best_volume
);
	localparam int LV_W  = $clog2(LEVELS);
	localparam int SY_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int ADR_W = LV_W + SY_W;
	localparam int DEPTH = SYMBOLS * (2 ** LV_W);
	// Tracked levels carry one extra bit: ask -1 is all ones, bid LEVELS is above range
	localparam int TL_W  = LV_W + 1;
	localparam int PR_W  = plbu_pkg::PRICE_W + plbu_pkg::TICK_W;
	localparam int SC_W  = PR_W - 8;
	localparam logic [TL_W-1:0] ASK_NONE = '1;
	localparam logic [TL_W-1:0] BID_NONE = TL_W'(LEVELS);
	localparam logic [ADR_W-1:0] ADR_LAST = ADR_W'(DEPTH - 1);

	logic [plbu_pkg::VOL_W-1:0] ask_mem [DEPTH];
	logic [plbu_pkg::VOL_W-1:0] bid_mem [DEPTH];
	logic [plbu_pkg::VOL_W-1:0] ask_rd_q, bid_rd_q;
	logic [TL_W-1:0] top_ask_q [SYMBOLS];
	logic [TL_W-1:0] top_bid_q [SYMBOLS];

	logic [ADR_W-1:0] clr_adr_q;
	logic             clr_done_q;
	logic [plbu_pkg::SYM_W-1:0]   sym_q;
	logic [plbu_pkg::PRICE_W-1:0] ask_px_q, bid_px_q;
	logic [plbu_pkg::VOL_W-1:0]   ask_vol_q, bid_vol_q;
	logic [SC_W-1:0]  ask_sc_q, bid_sc_q;
	logic [LV_W-1:0]  ask_lv_q, bid_lv_q;
	logic             in_range_q;
	logic [TL_W-1:0]  na_q, nb_q;
	logic             ask_need_q, bid_need_q;
	logic [LV_W:0]    scan_q;
	logic             scan_rd_q;
	logic [SY_W-1:0]  sidx;
	logic [PR_W-1:0]  ask_prod, bid_prod;

	assign sidx = SY_W'(sym_q);

	// Full-width price times tick products
	assign ask_prod = {{plbu_pkg::TICK_W{1'b0}}, ask_px_q} *
		{{plbu_pkg::PRICE_W{1'b0}}, tick_size};
	assign bid_prod = {{plbu_pkg::TICK_W{1'b0}}, bid_px_q} *
		{{plbu_pkg::PRICE_W{1'b0}}, tick_size};

	function automatic logic [LV_W-1:0] lvl_of(input logic [SC_W-1:0] sc,
		input logic [plbu_pkg::LB_W-1:0] lb);
		logic [SC_W:0] d;
		d = {1'b0, sc} - (SC_W+1)'(lb);
		return d[LV_W-1:0];
	endfunction

	function automatic logic ok_of(input logic [SC_W-1:0] sc,
		input logic [plbu_pkg::LB_W-1:0] lb);
		logic [SC_W:0] d;
		d = {1'b0, sc} - (SC_W+1)'(lb);
		return !d[SC_W] && (d[SC_W-1:0] < SC_W'(LEVELS));
	endfunction

	// Scan pointer address and end tests
	logic [LV_W-1:0] scan_lv;
	logic            ask_scan_end, bid_scan_end;
	logic            ask_hit, bid_hit;
	assign scan_lv      = scan_q[LV_W-1:0];
	assign ask_hit      = scan_rd_q && (ask_rd_q != '0);
	assign bid_hit      = scan_rd_q && (bid_rd_q != '0);

	always_comb begin
		sts.clear_done    = clr_done_q;
		sts.sym_ok        = (32'(sym_q) < SYMBOLS);
		sts.in_range      = ok_of(ask_sc_q, lower_bound) && ok_of(bid_sc_q, lower_bound);
		sts.ask_scan_need = ask_need_q;
		sts.bid_scan_need = bid_need_q;
		// Ask scan walks down; done on hit or after level 0 was examined
		ask_scan_end      = scan_rd_q && (scan_q[LV_W] || ask_hit);
		bid_scan_end      = scan_rd_q && ((scan_q == (LV_W+1)'(LEVELS)) || bid_hit);
		sts.ask_scan_done = ask_scan_end || (!scan_rd_q && scan_q[LV_W]);
		sts.bid_scan_done = bid_scan_end || (!scan_rd_q && scan_q >= (LV_W+1)'(LEVELS));
	end

	// Clearing pass over both memories after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_adr_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (cmd.clear_step && !clr_done_q) begin
			clr_adr_q <= clr_adr_q + 1'b1;
			if (clr_adr_q == ADR_LAST) clr_done_q <= 1'b1;
		end
	end

	// Memory ports: one write and one registered read per memory
	logic [ADR_W-1:0] ask_radr, bid_radr;
	always_comb begin
		ask_radr = {sidx, ask_lv_q};
		bid_radr = {sidx, bid_lv_q};
		if (cmd.ask_scan_step) ask_radr = {sidx, scan_lv};
		if (cmd.bid_scan_step) bid_radr = {sidx, scan_lv};
		// Top read uses the extremes that are being committed in the same cycle
		if (cmd.rd_top) begin
			ask_radr = {sidx, in_range_q ? na_q[LV_W-1:0] : top_ask_q[sidx][LV_W-1:0]};
			bid_radr = {sidx, in_range_q ? nb_q[LV_W-1:0] : top_bid_q[sidx][LV_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step && !clr_done_q) begin
			ask_mem[clr_adr_q] <= '0;
			bid_mem[clr_adr_q] <= '0;
		end else if (cmd.update) begin
			ask_mem[{sidx, ask_lv_q}] <= ask_vol_q;
			bid_mem[{sidx, bid_lv_q}] <= bid_vol_q;
		end
		ask_rd_q <= ask_mem[ask_radr];
		bid_rd_q <= bid_mem[bid_radr];
	end

	// Input capture, scaling and level checks
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sym_q     <= symbol;
			ask_px_q  <= ask_px;
			bid_px_q  <= bid_px;
			ask_vol_q <= ask_qty;
			bid_vol_q <= bid_qty;
		end
		if (cmd.scale) begin
			ask_sc_q <= ask_prod[PR_W-1:8];
			bid_sc_q <= bid_prod[PR_W-1:8];
		end
		if (cmd.check) begin
			ask_lv_q   <= lvl_of(ask_sc_q, lower_bound);
			bid_lv_q   <= lvl_of(bid_sc_q, lower_bound);
			in_range_q <= sts.sym_ok && sts.in_range;
		end
	end

	// New extremes and rescan decisions, decided when the levels are read and settled by the scans
	always_ff @(posedge clk) begin
		if (cmd.rd_levels) begin
			na_q <= top_ask_q[sidx];
			nb_q <= top_bid_q[sidx];
			ask_need_q <= 1'b0;
			bid_need_q <= 1'b0;
			if (ask_vol_q != '0) begin
				if (top_ask_q[sidx] == ASK_NONE || {1'b0, ask_lv_q} > top_ask_q[sidx])
					na_q <= {1'b0, ask_lv_q};
			end else if (top_ask_q[sidx] == {1'b0, ask_lv_q}) begin
				ask_need_q <= 1'b1;
			end
			if (bid_vol_q != '0) begin
				if ({1'b0, bid_lv_q} < top_bid_q[sidx]) nb_q <= {1'b0, bid_lv_q};
			end else if (top_bid_q[sidx] == {1'b0, bid_lv_q}) begin
				bid_need_q <= 1'b1;
			end
		end else if (cmd.ask_scan_step) begin
			if (ask_scan_end) begin
				ask_need_q <= 1'b0;
				na_q <= ask_hit ? TL_W'(scan_q + 1'b1) : ASK_NONE;
			end else if (!scan_rd_q && scan_q[LV_W]) begin
				// Cleared level 0: nothing below it
				ask_need_q <= 1'b0;
				na_q <= ASK_NONE;
			end
		end else if (cmd.bid_scan_step) begin
			if (bid_scan_end) begin
				bid_need_q <= 1'b0;
				nb_q <= bid_hit ? TL_W'(scan_q - 1'b1) : BID_NONE;
			end else if (!scan_rd_q && scan_q >= (LV_W+1)'(LEVELS)) begin
				// Cleared top level: nothing above it
				bid_need_q <= 1'b0;
				nb_q <= BID_NONE;
			end
		end
	end

	// Scan pointer: the read issued at scan_q returns in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			scan_rd_q <= 1'b0;
		end else if (cmd.ask_scan_start) begin
			scan_q    <= {1'b0, ask_lv_q} - 1'b1;
			scan_rd_q <= 1'b0;
		end else if (cmd.bid_scan_start) begin
			scan_q    <= {1'b0, bid_lv_q} + 1'b1;
			scan_rd_q <= 1'b0;
		end else if (cmd.ask_scan_step) begin
			scan_q    <= scan_q - 1'b1;
			scan_rd_q <= !scan_q[LV_W];
		end else if (cmd.bid_scan_step) begin
			scan_q    <= scan_q + 1'b1;
			scan_rd_q <= (scan_q < (LV_W+1)'(LEVELS));
		end
	end

	// Tracked extremes per symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOLS; i++) begin
				top_ask_q[i] <= ASK_NONE;
				top_bid_q[i] <= BID_NONE;
			end
		end else if (cmd.rd_top && in_range_q) begin
			top_ask_q[sidx] <= na_q;
			top_bid_q[sidx] <= nb_q;
		end
	end

	// Result register
	logic ta_ok, tb_ok;
	assign ta_ok = (top_ask_q[sidx] != ASK_NONE);
	assign tb_ok = (top_bid_q[sidx] < BID_NONE);
	always_ff @(posedge clk) begin
		if (cmd.make_result) begin
			accepted        <= sts.sym_ok && in_range_q;
			ask_best_valid  <= sts.sym_ok && ta_ok;
			bid_best_valid  <= sts.sym_ok && tb_ok;
			ask_best_level  <= (sts.sym_ok && ta_ok) ?
				plbu_pkg::LVL_W'(top_ask_q[sidx][LV_W-1:0]) : '0;
			bid_best_level  <= (sts.sym_ok && tb_ok) ?
				plbu_pkg::LVL_W'(top_bid_q[sidx][LV_W-1:0]) : '0;
			ask_best_volume <= (sts.sym_ok && ta_ok) ? ask_rd_q : '0;
			bid_best_volume <= (sts.sym_ok && tb_ok) ? bid_rd_q : '0;
		end
	end

	// A tracked ask is never at or above the level count unless none
	ast_ask_rng: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.make_result |-> (top_ask_q[sidx] == ASK_NONE || top_ask_q[sidx] < BID_NONE))
		else $error("ask tracker out of range");
	// Bid tracker never exceeds the none marker
	ast_bid_rng: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.make_result |-> top_bid_q[sidx] <= BID_NONE)
		else $error("bid tracker out of range");
	// Memories are never updated before clearing finished
	ast_upd_after_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> clr_done_q)
		else $error("update before clear done");
endmodule
`default_nettype wire
